/* design/rrrs_pkg.sv */
// ----------------------------------------------------------------------------
// rrrs_pkg
// Types, constants and helper functions of the ring refill rate scheduler.
// ----------------------------------------------------------------------------
package rrrs_pkg;

	localparam int NUM_CHANNELS = 4;
	localparam int RING_USABLE  = 4095;
	localparam int MAX_CHUNK    = 1024;
	localparam int SLOTS        = 8;

	localparam int CH_W   = 2;
	localparam int ROFF_W = 12;
	localparam int CNT_W  = 11;
	localparam int SLOT_W = 4;

	localparam logic [17:0] RATE_NUM   = 18'd223152;
	localparam logic [14:0] RATE_MUL   = 15'd20832;
	localparam logic [19:0] SRC_BASE   = 20'h60000;
	localparam logic [15:0] PERIOD_RST = 16'd856;
	localparam logic [15:0] PERIOD_MIN = 16'd4;

	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_SETUP  = 2'd1,
		OP_STOP   = 2'd2,
		OP_PERIOD = 2'd3
	} op_t;

	typedef enum logic {
		KIND_COPY = 1'b0,
		KIND_STOP = 1'b1
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_USE,
		ST_DIV,
		ST_MUL,
		ST_ACC,
		ST_PIECE,
		ST_WB
	} state_t;

	typedef struct packed {
		logic        active;
		logic [19:0] base;
		logic [17:0] len;
		logic [17:0] pos;
		logic [11:0] ring;
		logic [15:0] period;
		logic [15:0] frac;
		logic        done;
	} chan_t;

	typedef struct packed {
		kind_t       kind;
		logic [1:0]  ch;
		logic [15:0] addr;
		logic [19:0] src;
		logic [10:0] len;
	} res_t;

	localparam chan_t CHAN_RST = '{
		active: 1'b0, base: '0, len: '0, pos: '0, ring: '0,
		period: PERIOD_RST, frac: '0, done: 1'b0
	};

	function automatic logic [15:0] ring_start_addr(input logic [1:0] ch);
		return 16'((32'h0C0 + 32'(ch) * 32'h010) << 8);
	endfunction

	function automatic logic [11:0] ring_wrap(input logic [12:0] sum);
		if (sum >= 13'(RING_USABLE))
			return 12'(sum - 13'(RING_USABLE));
		else
			return 12'(sum);
	endfunction

endpackage

/* design/ring_refill_rate_scheduler.sv */
// ----------------------------------------------------------------------------
// ring_refill_rate_scheduler
// Schedules refills of per-channel sample rings and emits copy and stop commands.
// ----------------------------------------------------------------------------
// Steps: a stop or period item runs read, use and write-back; a setup adds its
// copy pieces when its first chunk is not empty; a tick runs these for each
// channel, and for an active one the 18-step serial divider, multiply and accumulate.
// Each result leaves on a one-cycle strobe, through the output register, after the next result is formed or,
// for the last one, in the cycle after the item ends. One item at a time.
// Reset clears the channel valid bits, so every entry reads as its reset value.
module ring_refill_rate_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [1:0]  channel,
	input  logic [19:0] src_start,
	input  logic [17:0] src_length,
	input  logic [15:0] period,
	output logic        strobe,
	output logic        kind,
	output logic [1:0]  out_channel,
	output logic [15:0] pcm_addr,
	output logic [19:0] src_addr,
	output logic [10:0] length,
	output logic        last
);
	import rrrs_pkg::*;

	state_t      state_q, state_d;
	op_t         op_q;
	logic [1:0]  ch_q;
	logic [19:0] start_q;
	logic [17:0] slen_q;
	logic [15:0] per_q;

	chan_t       mem [NUM_CHANNELS];
	chan_t       rd_q;
	logic [NUM_CHANNELS-1:0] valid_q;
	chan_t       cur_q;

	logic [17:0] rem_q, quo_q;
	logic [4:0]  dcnt_q;
	logic [31:0] prod_q;

	logic [10:0] cnt_q;
	logic [11:0] roff_q;
	logic [19:0] src_q;
	logic [SLOT_W-1:0] slot_q;

	res_t        pend_q, out_q;
	logic        pend_v_q, strobe_q, last_q;

	chan_t       ent, ent_n;
	logic [17:0] first;
	logic [17:0] div_d, trial;
	logic [31:0] acc;
	logic [17:0] remain, bytes;
	logic [11:0] roff_e, avail;
	logic        emit_v, fin, piece_end;
	res_t        emit_r;

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		ent = valid_q[ch_q] ? rd_q : CHAN_RST;
		first = (slen_q > 18'(MAX_CHUNK)) ? 18'(MAX_CHUNK) : slen_q;
		ent_n = ent;
		case (op_q)
			OP_STOP: ent_n.active = 1'b0;
			OP_PERIOD: ent_n.period = per_q;
			OP_SETUP: begin
				ent_n.active = 1'b1;
				ent_n.base   = start_q;
				ent_n.len    = slen_q;
				ent_n.frac   = '0;
				ent_n.done   = 1'b0;
				ent_n.pos    = first;
				ent_n.ring   = ring_wrap(13'(first));
			end
			OP_TICK: begin
				if (ent.active && ent.period >= PERIOD_MIN && ent.pos >= ent.len)
					ent_n.done = 1'b1;
			end
			default: ;
		endcase
		div_d = 18'(cur_q.period) + 18'd1;
		trial = {rem_q[16:0], RATE_NUM[dcnt_q]};
		acc = 32'(cur_q.frac) + prod_q;
		remain = cur_q.len - cur_q.pos;
		bytes = 18'(acc[31:16]);
		if (bytes > 18'(MAX_CHUNK))
			bytes = 18'(MAX_CHUNK);
		if (bytes > remain)
			bytes = remain;
		roff_e = (roff_q >= 12'(RING_USABLE)) ? 12'd0 : roff_q;
		avail = 12'(RING_USABLE) - roff_e;
		if (avail > 12'(cnt_q))
			avail = 12'(cnt_q);
		piece_end = (12'(cnt_q) == avail);
	end

	always_comb begin
		state_d = state_q;
		emit_v = 1'b0;
		emit_r = '{kind: KIND_STOP, ch: ch_q, addr: ring_start_addr(ch_q), src: '0,
			len: 11'd1};
		fin = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start)
					state_d = ST_RD;
			end
			ST_RD: state_d = ST_USE;
			ST_USE: begin
				state_d = ST_WB;
				case (op_q)
					OP_SETUP: begin
						emit_v = 1'b1;
						emit_r.addr = 16'(ring_start_addr(ch_q) + 16'(RING_USABLE));
						if (first != 18'd0)
							state_d = ST_PIECE;
					end
					OP_TICK: begin
						if (ent.active && ent.period >= PERIOD_MIN) begin
							if (ent.pos >= ent.len)
								emit_v = !ent.done;
							else
								state_d = ST_DIV;
						end
					end
					default: state_d = ST_WB;
				endcase
			end
			ST_DIV: begin
				if (dcnt_q == 5'd0)
					state_d = ST_MUL;
			end
			ST_MUL: state_d = ST_ACC;
			ST_ACC: begin
				state_d = (bytes == 18'd0) ? ST_WB : ST_PIECE;
			end
			ST_PIECE: begin
				emit_v = 1'b1;
				emit_r.kind = KIND_COPY;
				emit_r.addr = 16'(ring_start_addr(ch_q) + 16'(roff_e));
				emit_r.src = src_q;
				emit_r.len = 11'(avail);
				if (piece_end)
					state_d = ST_WB;
			end
			ST_WB: begin
				if (op_q == OP_TICK && ch_q != 2'(NUM_CHANNELS - 1)) begin
					state_d = ST_RD;
				end else begin
					state_d = ST_IDLE;
					fin = 1'b1;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		if (slot_q >= SLOT_W'(SLOTS))
			emit_v = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			valid_q  <= '0;
			pend_v_q <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_WB)
				valid_q[ch_q] <= 1'b1;
			strobe_q <= (emit_v || fin) && pend_v_q;
			if (emit_v)
				pend_v_q <= 1'b1;
			else if (fin)
				pend_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RD)
			rd_q <= mem[ch_q];
		if (state_q == ST_WB)
			mem[ch_q] <= cur_q;
	end

	always_ff @(posedge clk) begin
		if (emit_v) begin
			out_q  <= pend_q;
			last_q <= 1'b0;
			pend_q <= emit_r;
			slot_q <= slot_q + SLOT_W'(1);
		end else if (fin) begin
			out_q  <= pend_q;
			last_q <= 1'b1;
		end
		case (state_q)
			ST_IDLE: begin
				op_q    <= op_t'(opcode);
				ch_q    <= (op_t'(opcode) == OP_TICK) ? 2'd0 : channel;
				start_q <= src_start;
				slen_q  <= src_length;
				per_q   <= period;
				slot_q  <= '0;
			end
			ST_USE: begin
				cur_q <= ent_n;
				if (op_q == OP_SETUP) begin
					cnt_q  <= 11'(first);
					roff_q <= '0;
					src_q  <= 20'(SRC_BASE + start_q);
				end
				if (op_q == OP_TICK) begin
					rem_q  <= '0;
					dcnt_q <= 5'd17;
				end
			end
			ST_DIV: begin
				if (trial >= div_d) begin
					rem_q <= trial - div_d;
					quo_q <= {quo_q[16:0], 1'b1};
				end else begin
					rem_q <= trial;
					quo_q <= {quo_q[16:0], 1'b0};
				end
				dcnt_q <= dcnt_q - 5'd1;
			end
			ST_MUL: prod_q <= 32'(quo_q * RATE_MUL);
			ST_ACC: begin
				cur_q.frac <= acc[15:0];
				cur_q.pos  <= cur_q.pos + bytes;
				cur_q.ring <= ring_wrap(13'(cur_q.ring) + 13'(bytes));
				cnt_q  <= 11'(bytes);
				roff_q <= cur_q.ring;
				src_q  <= 20'(SRC_BASE + cur_q.base + 20'(cur_q.pos));
			end
			ST_PIECE: begin
				cnt_q  <= cnt_q - 11'(avail);
				roff_q <= roff_e + avail;
				src_q  <= src_q + 20'(avail);
			end
			ST_WB: begin
				ch_q <= ch_q + 2'd1;
			end
			default: ;
		endcase
	end

	assign strobe      = strobe_q;
	assign kind        = out_q.kind;
	assign out_channel = out_q.ch;
	assign pcm_addr    = out_q.addr;
	assign src_addr    = out_q.src;
	assign length      = out_q.len;
	assign last        = last_q;

endmodule
